@@ sv/dsfp_pkg.sv @@
// Package for the delta-seconds field parser.
// Holds the parse phase type, the staged item type and the character codes.
// No dependencies.
`default_nettype none

package dsfp_pkg;

    localparam int AGE_W  = 64;
    localparam int CHAR_W = 8;
    localparam int DIG_W  = 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [AGE_W-1:0] AGE_SAT = {AGE_W{1'b1}};

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_DIG   = 3'd1,
        PH_TRAIL = 3'd2,
        PH_GOOD  = 3'd3,
        PH_BAD   = 3'd4
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] char_byte;
        logic              is_last;
    } t_item;

endpackage

`default_nettype wire

@@ sv/dsfp_in_stage.sv @@
// Input register of the delta-seconds field parser.
// Captures one item per cycle and holds it while the parse core cannot take it.
// Depends on dsfp_pkg.
`default_nettype none

module dsfp_in_stage
    import dsfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char_byte,
    input  wire logic              i_is_last,
    output logic                   o_stall,
    input  wire logic              i_take,
    output t_item                  o_item
);

    t_item r_item;

    assign o_stall = r_item.valid && !i_take;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (!o_stall) begin
            r_item.valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_item.char_byte <= i_char_byte;
            r_item.is_last   <= i_is_last;
        end
    end

endmodule

`default_nettype wire

@@ sv/dsfp_core.sv @@
// Parse core of the delta-seconds field parser.
// Holds the parse phase, the saturating accumulator and the result register.
// Depends on dsfp_pkg.
`default_nettype none

module dsfp_core
    import dsfp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_item            i_item,
    output logic                  o_take,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_field_valid,
    output logic [AGE_W-1:0]      o_age_seconds
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [AGE_W-1:0]  r_acc;
    logic [AGE_W-1:0]  n_acc;
    logic              r_out_valid;
    logic              r_field_valid;
    logic [AGE_W-1:0]  r_age;

    logic              is_blank;
    logic              is_term;
    logic              is_digit;
    logic [DIG_W-1:0]  digit;
    logic [AGE_W+3:0]  acc_sum;
    logic [AGE_W-1:0]  acc_next;
    logic              acc_step;
    logic              field_ok;
    logic              step;
    logic              out_free;

    assign is_blank = (i_item.char_byte == CHAR_SPACE) || (i_item.char_byte == CHAR_TAB);
    assign is_term  = (i_item.char_byte == CHAR_COMMA) || (i_item.char_byte == CHAR_NUL);
    assign is_digit = (i_item.char_byte >= CHAR_ZERO) && (i_item.char_byte <= CHAR_NINE);
    assign digit    = DIG_W'(i_item.char_byte - CHAR_ZERO);

    // value*10 + digit, saturate when any bit above the word is set
    assign acc_sum  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{AGE_W{1'b0}}, digit};
    assign acc_next = (acc_sum[AGE_W+3:AGE_W] != 4'd0) ? AGE_SAT : acc_sum[AGE_W-1:0];

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_LEAD: begin
                if (is_blank) begin
                    n_phase = PH_LEAD;
                end else if (is_digit) begin
                    n_phase = PH_DIG;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_DIG: begin
                if (is_digit) begin
                    n_phase = PH_DIG;
                end else if (is_blank) begin
                    n_phase = PH_TRAIL;
                end else if (is_term) begin
                    n_phase = PH_GOOD;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (is_blank) begin
                    n_phase = PH_TRAIL;
                end else if (is_term) begin
                    n_phase = PH_GOOD;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_comb begin
        acc_step = is_digit && ((r_phase == PH_LEAD) || (r_phase == PH_DIG));
        field_ok = (n_phase == PH_DIG) || (n_phase == PH_TRAIL) || (n_phase == PH_GOOD);
        n_acc    = acc_step ? acc_next : r_acc;
    end

    assign out_free = !r_out_valid || !i_stall;
    assign o_take   = !i_item.is_last || out_free;
    assign step     = i_item.valid && o_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
            r_acc   <= '0;
        end else if (step) begin
            if (i_item.is_last) begin
                r_phase <= PH_LEAD;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && i_item.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && i_item.is_last) begin
            r_field_valid <= field_ok;
            r_age         <= field_ok ? n_acc : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_field_valid = r_field_valid;
    assign o_age_seconds = r_age;

endmodule

`default_nettype wire

@@ sv/delta_seconds_field_parser_unit.sv @@
// Delta-seconds field parser: one header byte per item, one result per value.
// Path: the last byte passes the input register, then the result register that drives o_valid.
// Throughput: 1 item per cycle while o_stall is low; the input register and the result register
// let a new byte enter while a result waits to be taken.
// Reset: synchronous, active low; clears both valids, the phase and the value.
// Depends on dsfp_pkg, dsfp_in_stage and dsfp_core.
`default_nettype none

module delta_seconds_field_parser_unit
    import dsfp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [CHAR_W-1:0] i_char_byte,
    input  wire logic              i_is_last,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic                   o_field_valid,
    output logic [AGE_W-1:0]       o_age_seconds
);

    t_item item;
    logic  take;

    dsfp_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_char_byte (i_char_byte),
        .i_is_last   (i_is_last),
        .o_stall     (o_stall),
        .i_take      (take),
        .o_item      (item)
    );

    dsfp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (item),
        .o_take        (take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_valid (o_field_valid),
        .o_age_seconds (o_age_seconds)
    );

endmodule

`default_nettype wire

@@ sv/dsfp_checker.sv @@
// Port checker for the delta-seconds field parser, bound to the top level.
// Depends on dsfp_pkg.
`default_nettype none

module dsfp_checker
    import dsfp_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_stall,
    input wire logic              o_valid,
    input wire logic              i_stall,
    input wire logic              o_field_valid,
    input wire logic [AGE_W-1:0]  o_age_seconds
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_field_valid) && $stable(o_age_seconds)))
        else $error("result changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_field_valid) |-> (o_age_seconds == '0))
        else $error("invalid field with nonzero value");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(i_valid) && !$past(o_stall)) |-> !o_stall)
        else $error("input stalled with no item held");

endmodule

bind delta_seconds_field_parser_unit dsfp_checker u_dsfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_field_valid (o_field_valid),
    .o_age_seconds (o_age_seconds)
);

`default_nettype wire

@@ tb/delta_seconds_field_parser_unit_tb.sv @@
`timescale 1ns / 100ps
// Testbench for delta_seconds_field_parser_unit: header bytes go in one per item,
// and a scoreboard predicts each value's valid flag and age and checks the results.
// Depends on dsfp_pkg and the parser unit only.

module delta_seconds_field_parser_unit_tb;
    import dsfp_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [AGE_W-1:0] age;
    } t_age_result;

    typedef logic [CHAR_W-1:0] t_char_q[$];

    localparam int RANDOM_ITEMS = 1200;

    class age_scoreboard;
        t_phase           phase = PH_LEAD;
        logic [AGE_W-1:0] acc   = '0;
        t_age_result      expected_ages[$];
        int               errors        = 0;
        int               results       = 0;
        int               valid_results = 0;
        int               saturated     = 0;

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function logic [AGE_W-1:0] times_ten_plus(logic [AGE_W-1:0] a, logic [CHAR_W-1:0] c);
            logic [CHAR_W-1:0] dig8;
            logic [AGE_W-1:0]  d;
            dig8 = c - CHAR_ZERO;
            d    = AGE_W'(dig8);
            if (a > (AGE_SAT - d) / 10) return AGE_SAT;
            return a * 10 + d;
        endfunction

        function void note_char(logic [CHAR_W-1:0] c, logic last);
            logic        blank;
            logic        term;
            logic        digit;
            t_age_result r;
            blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
            term  = (c == CHAR_COMMA) || (c == CHAR_NUL);
            digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            case (phase)
                PH_LEAD: begin
                    if (digit) begin
                        acc   = times_ten_plus(acc, c);
                        phase = PH_DIG;
                    end else if (!blank) begin
                        phase = PH_BAD;
                    end
                end
                PH_DIG: begin
                    if (digit) acc = times_ten_plus(acc, c);
                    else if (blank) phase = PH_TRAIL;
                    else if (term) phase = PH_GOOD;
                    else phase = PH_BAD;
                end
                PH_TRAIL: begin
                    if (term) phase = PH_GOOD;
                    else if (!blank) phase = PH_BAD;
                end
                default: ;
            endcase
            if (last) begin
                r.ok  = (phase == PH_DIG) || (phase == PH_TRAIL) || (phase == PH_GOOD);
                r.age = r.ok ? acc : '0;
                expected_ages.push_back(r);
                phase = PH_LEAD;
                acc   = '0;
            end
        endfunction

        function void check_result(logic fv, logic [AGE_W-1:0] age);
            t_age_result r;
            results++;
            if (expected_ages.size() == 0) begin
                report($sformatf("unexpected result valid=%0b age=%0d", fv, age));
                return;
            end
            r = expected_ages.pop_front();
            if (fv !== r.ok)
                report($sformatf("field_valid %0b, expected %0b", fv, r.ok));
            if (age !== r.age)
                report($sformatf("age_seconds %0d, expected %0d", age, r.age));
            if (r.ok) valid_results++;
            if (r.ok && r.age == AGE_SAT) saturated++;
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic [CHAR_W-1:0] i_char_byte = '0;
    logic              i_is_last   = 1'b0;
    logic              i_stall     = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic              o_field_valid;
    logic [AGE_W-1:0]  o_age_seconds;

    age_scoreboard sb = new;
    bit            quiet       = 1'b0;
    int            items_sent  = 0;
    int            values_sent = 0;

    delta_seconds_field_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_byte   (i_char_byte),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_valid (o_field_valid),
        .o_age_seconds (o_age_seconds)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !quiet && ($urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_field_valid, o_age_seconds);
    end

    task automatic send_char(logic [CHAR_W-1:0] c, logic last);
        while (!quiet && $urandom_range(99) < 13) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_char_byte <= c;
        i_is_last   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_char(c, last);
        items_sent++;
    endtask

    task automatic send_bytes(t_char_q b);
        foreach (b[k]) send_char(b[k], k == b.size() - 1);
        values_sent++;
    endtask

    // hold input until every predicted result has been taken
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.expected_ages.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] rand_blank();
        return $urandom_range(1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CHAR_ZERO + CHAR_W'($urandom_range(9));
    endfunction

    task automatic send_random_value();
        t_char_q b;
        int      pick;
        int      n;
        pick = $urandom_range(99);
        if (pick < 70) begin
            repeat ($urandom_range(3)) b.push_back(rand_blank());
            n = ($urandom_range(9) == 0) ? $urandom_range(24, 18) : $urandom_range(6, 1);
            repeat (n) b.push_back(rand_digit());
            repeat ($urandom_range(2)) b.push_back(rand_blank());
            if ($urandom_range(1)) begin
                b.push_back($urandom_range(1) ? CHAR_COMMA : CHAR_NUL);
                repeat ($urandom_range(4)) b.push_back(CHAR_W'($urandom_range(255)));
            end
        end else if (pick < 85) begin
            repeat ($urandom_range(2)) b.push_back(rand_blank());
            case ($urandom_range(2))
                0: begin
                    if ($urandom_range(1)) b.push_back($urandom_range(1) ? CHAR_COMMA : CHAR_NUL);
                    else b.push_back(rand_blank());
                end
                1: begin
                    b.push_back(rand_digit());
                    repeat ($urandom_range(2, 1)) b.push_back(rand_blank());
                    b.push_back(rand_digit());
                end
                default: begin
                    repeat ($urandom_range(3)) b.push_back(rand_digit());
                    b.push_back(CHAR_W'($urandom_range(255)));
                    repeat ($urandom_range(3)) b.push_back(rand_digit());
                end
            endcase
        end else begin
            repeat ($urandom_range(6, 1)) b.push_back(CHAR_W'($urandom_range(255)));
        end
        send_bytes(b);
    endtask

    initial begin
        int guard;
        int directed_items;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_bytes('{CHAR_ZERO});
        send_bytes('{CHAR_SPACE, CHAR_TAB, CHAR_ZERO + 8'd5, CHAR_SPACE, CHAR_TAB});
        send_bytes('{CHAR_COMMA});
        send_bytes('{CHAR_NUL});
        send_bytes('{CHAR_ZERO + 8'd3, CHAR_SPACE, CHAR_ZERO + 8'd4});
        send_bytes('{CHAR_ZERO + 8'd1, CHAR_NINE, CHAR_COMMA, 8'hFF, CHAR_ZERO});
        send_bytes('{CHAR_NINE, 8'h78});
        send_bytes('{CHAR_TAB});
        send_bytes('{CHAR_ZERO + 8'd7, CHAR_SPACE, CHAR_NUL, CHAR_ZERO});
        drain_results();
        directed_items = items_sent;

        while (items_sent < directed_items + RANDOM_ITEMS) begin
            quiet = (items_sent > directed_items + 500) && (items_sent < directed_items + 800);
            if (values_sent == 80) drain_results();
            send_random_value();
        end
        quiet = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;
        guard = 0;
        while (sb.expected_ages.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.expected_ages.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.expected_ages.size()));

        $display("Sent %0d header bytes in %0d values; checked %0d results.",
                 items_sent, values_sent, sb.results);
        $display("%0d results were valid fields, %0d of them saturated.",
                 sb.valid_results, sb.saturated);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

@@ delta_seconds_field_parser_unit.f @@
sv/dsfp_pkg.sv
sv/dsfp_in_stage.sv
sv/dsfp_core.sv
sv/delta_seconds_field_parser_unit.sv
sv/dsfp_checker.sv
tb/delta_seconds_field_parser_unit_tb.sv
